FILE: src/lses_pkg.sv
// Shared constants and types for the latency start/end statistics unit.
package lses_pkg;

  // Width of the time counter that is actually used (32 to 64).
  localparam int TIME_WIDTH = 64;

  // Mask that keeps the low TIME_WIDTH bits of a 64-bit timestamp.
  localparam logic [63:0] TIME_MASK = {64{1'b1}} >> (64 - TIME_WIDTH);

  // Reset value of the running minimum.
  localparam logic [31:0] MIN_RESET = 32'hFFFF_FFFF;

  // Reset value of the clock period register.
  localparam logic [7:0] PERIOD_RESET = 8'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // Capture an accepted input word.
    logic eval;  // Apply clear, start and end, form the tick difference.
    logic mul;   // Scale the difference by the clock period.
    logic sqr;   // Square the latency.
    logic fin;   // Update the statistics and load the output register.
  } lses_cmd_t;

endpackage

FILE: src/lses_ctrl.sv
// Sequencing controller and output handshake for the statistics unit.
module lses_ctrl import lses_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output lses_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       fin_ok;

  // The last step may run once the output register is free or being emptied.
  assign fin_ok   = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SQR;
      S_SQR:  state_nxt = S_FIN;
      S_FIN:  if (fin_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (fin_ok) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath commands.
  always_comb begin
    cmd.load = in_valid && (state_r == S_IDLE);
    cmd.eval = (state_r == S_EVAL);
    cmd.mul  = (state_r == S_MUL);
    cmd.sqr  = (state_r == S_SQR);
    cmd.fin  = fin_ok;
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/lses_datapath.sv
// Measurement state, latency arithmetic, statistics and output register.
module lses_datapath import lses_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lses_cmd_t   cmd,
  input  logic        cfg_write_enable,
  input  logic [7:0]  cfg_write_data,
  input  logic [63:0] in_time_now,
  input  logic        in_start_trigger,
  input  logic        in_end_trigger,
  input  logic [15:0] in_op_tag,
  input  logic [7:0]  in_operation_kind,
  input  logic        in_clear_request,
  input  logic        in_enable_flag,
  output logic        out_record_done,
  output logic [63:0] out_record_start_time,
  output logic [63:0] out_record_end_time,
  output logic [15:0] out_record_op_tag,
  output logic [7:0]  out_record_operation_kind,
  output logic [63:0] out_sample_total,
  output logic [63:0] out_latency_sum,
  output logic [63:0] out_latency_square_sum,
  output logic [31:0] out_latency_min,
  output logic [31:0] out_latency_max
);

  // Captured input word.
  logic [63:0] now_r;
  logic        start_r;
  logic        end_r;
  logic [15:0] id_r;
  logic [7:0]  kind_r;
  logic        clear_r;
  logic        enable_r;

  // Configuration and measurement state.
  logic [7:0]  period_r;
  logic        busy_r;
  logic [63:0] stamp_r;
  logic [15:0] held_id_r;
  logic [7:0]  held_kind_r;
  logic [63:0] count_r;
  logic [63:0] sum_r;
  logic [63:0] square_r;
  logic [31:0] min_r;
  logic [31:0] max_r;

  // Work registers of the current word.
  logic        rec_r;
  logic [31:0] diff_r;
  logic [31:0] lat_r;
  logic [63:0] lat_sq_r;

  // Evaluation step: clear first, then start, then end.
  logic        busy_clr;
  logic        start_ok;
  logic        busy_started;
  logic        end_ok;
  logic [63:0] stamp_nxt;
  logic [39:0] scaled;

  assign busy_clr     = clear_r ? 1'b0 : busy_r;
  assign start_ok     = enable_r && start_r && !busy_clr;
  assign busy_started = busy_clr || start_ok;
  assign end_ok       = enable_r && end_r && busy_started;
  assign stamp_nxt    = start_ok ? now_r : stamp_r;
  assign scaled       = 40'(diff_r) * 40'(period_r);

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r    <= in_time_now & TIME_MASK;
      start_r  <= in_start_trigger;
      end_r    <= in_end_trigger;
      id_r     <= in_op_tag;
      kind_r   <= in_operation_kind;
      clear_r  <= in_clear_request;
      enable_r <= in_enable_flag;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_write_enable) begin
      period_r <= cfg_write_data;
    end
  end

  // Measurement and statistics state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      stamp_r     <= '0;
      held_id_r   <= '0;
      held_kind_r <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      square_r    <= '0;
      min_r       <= MIN_RESET;
      max_r       <= '0;
    end else if (cmd.eval) begin
      busy_r  <= end_ok ? 1'b0 : busy_started;
      stamp_r <= stamp_nxt;
      if (start_ok) begin
        held_id_r   <= id_r;
        held_kind_r <= kind_r;
      end
      if (clear_r) begin
        count_r  <= '0;
        sum_r    <= '0;
        square_r <= '0;
        min_r    <= MIN_RESET;
        max_r    <= '0;
      end
    end else if (cmd.fin && rec_r) begin
      count_r  <= count_r + 64'd1;
      sum_r    <= sum_r + {32'd0, lat_r};
      square_r <= square_r + lat_sq_r;
      if (lat_r < min_r) min_r <= lat_r;
      if (lat_r > max_r) max_r <= lat_r;
    end
  end

  // Tick difference, scaling and squaring, one step per cycle.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rec_r  <= end_ok;
      diff_r <= now_r[31:0] - stamp_nxt[31:0];
    end
    if (cmd.mul) begin
      lat_r <= scaled[31:0];
    end
    if (cmd.sqr) begin
      lat_sq_r <= {32'd0, lat_r} * {32'd0, lat_r};
    end
  end

  // Output register; the statistics include this word's update.
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_record_done           <= rec_r;
      out_record_start_time     <= rec_r ? stamp_r : 64'd0;
      out_record_end_time       <= rec_r ? now_r : 64'd0;
      out_record_op_tag         <= rec_r ? held_id_r : 16'd0;
      out_record_operation_kind <= rec_r ? held_kind_r : 8'd0;
      out_sample_total          <= rec_r ? count_r + 64'd1 : count_r;
      out_latency_sum           <= rec_r ? sum_r + {32'd0, lat_r} : sum_r;
      out_latency_square_sum    <= rec_r ? square_r + lat_sq_r : square_r;
      out_latency_min           <= (rec_r && lat_r < min_r) ? lat_r : min_r;
      out_latency_max           <= (rec_r && lat_r > max_r) ? lat_r : max_r;
    end
  end

endmodule

FILE: src/latency_start_end_statistics_unit.sv
// Top level of the latency start/end statistics unit.
// Each input word carries a time stamp, start and end triggers, an operation
// id and kind, a clear request and an enable; each word yields exactly one
// output word with an optional completion record and the running count, sum,
// sum of squares, minimum and maximum of the latency in nanoseconds. The
// accepting cycle captures a word, then the controller walks in sequence
// through evaluation of clear/start/end with the tick difference, scaling by
// the clock period (32x8 multiplier), squaring (32x32 multiplier) and the
// accumulate step, which loads the output word; the next word can be
// accepted in the cycle after the accumulate step.
// The next word is accepted while a finished word still waits in the output
// register; the accumulate step waits only while it is full and unread.
// The clock period register may be written only while no word is in flight.
module latency_start_end_statistics_unit import lses_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_enable,
  input  logic [7:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_time_now,
  input  logic        in_start_trigger,
  input  logic        in_end_trigger,
  input  logic [15:0] in_op_tag,
  input  logic [7:0]  in_operation_kind,
  input  logic        in_clear_request,
  input  logic        in_enable_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_record_done,
  output logic [63:0] out_record_start_time,
  output logic [63:0] out_record_end_time,
  output logic [15:0] out_record_op_tag,
  output logic [7:0]  out_record_operation_kind,
  output logic [63:0] out_sample_total,
  output logic [63:0] out_latency_sum,
  output logic [63:0] out_latency_square_sum,
  output logic [31:0] out_latency_min,
  output logic [31:0] out_latency_max
);

  lses_cmd_t cmd;

  // Sequencer and output handshake.
  lses_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  lses_datapath u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .cfg_write_enable          (cfg_write_enable),
    .cfg_write_data            (cfg_write_data),
    .in_time_now               (in_time_now),
    .in_start_trigger          (in_start_trigger),
    .in_end_trigger            (in_end_trigger),
    .in_op_tag                 (in_op_tag),
    .in_operation_kind         (in_operation_kind),
    .in_clear_request          (in_clear_request),
    .in_enable_flag            (in_enable_flag),
    .out_record_done           (out_record_done),
    .out_record_start_time     (out_record_start_time),
    .out_record_end_time       (out_record_end_time),
    .out_record_op_tag         (out_record_op_tag),
    .out_record_operation_kind (out_record_operation_kind),
    .out_sample_total          (out_sample_total),
    .out_latency_sum           (out_latency_sum),
    .out_latency_square_sum    (out_latency_square_sum),
    .out_latency_min           (out_latency_min),
    .out_latency_max           (out_latency_max)
  );

endmodule

FILE: src/lses_checker.sv
// Port-level checks for the latency start/end statistics unit, bound to the top.
module lses_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_record_done,
  input logic [63:0] out_record_start_time,
  input logic [63:0] out_record_end_time,
  input logic [15:0] out_record_op_tag,
  input logic [63:0] out_sample_total,
  input logic [31:0] out_latency_min,
  input logic [31:0] out_latency_max
);

  // A stalled output word holds its sample total.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_total))
    else $error("output word changed while stalled");

  // One word is worked on at a time: an accepted word closes the input side.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  // Without a record the record fields read as zero.
  a_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_done |-> out_record_start_time == 64'd0 &&
      out_record_end_time == 64'd0 && out_record_op_tag == 16'd0)
    else $error("record fields not cleared without a record");

  // On a word with a record, the minimum never exceeds the maximum.
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_done |-> out_latency_min <= out_latency_max)
    else $error("latency minimum above maximum after a record");

endmodule

bind latency_start_end_statistics_unit lses_checker u_lses_checker (.*);
